@@ rtl/wps_pkg.sv @@
// ---------------------------------------------------------------------------
// wps_pkg: shared types and constants for the wrapped pid step block
// field widths, register indexes, item codes and unit status
// ---------------------------------------------------------------------------
package wps_pkg;

    // default width of the measured sample
    localparam int DATA_WIDTH_DEF = 16;

    // fixed field widths
    localparam int GAIN_W  = 16;
    localparam int HALF_W  = 14;
    localparam int LIM_W   = 15;
    localparam int DRIVE_W = 16;
    localparam int ERR_W   = 15;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;

    // internal widths: wrapped values stay inside (-3*half, half)
    localparam int WRAP_W  = 17;
    localparam int REM_W   = HALF_W + 1;
    localparam int PROD_W  = GAIN_W + WRAP_W;
    localparam int INTEG_W = PROD_W + 1;
    localparam int ACC_W   = PROD_W + 3;

    localparam logic [HALF_W-1:0] HALF_RST = HALF_W'(16383);

    // register indexes
    localparam logic [IDX_W-1:0] REG_GAIN_P      = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_I      = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_D      = 3'd2;
    localparam logic [IDX_W-1:0] REG_SETPOINT    = 3'd3;
    localparam logic [IDX_W-1:0] REG_WRAP_HALF   = 3'd4;
    localparam logic [IDX_W-1:0] REG_INTEG_BAND  = 3'd5;
    localparam logic [IDX_W-1:0] REG_INTEG_LIMIT = 3'd6;
    localparam logic [IDX_W-1:0] REG_DRIVE_LIMIT = 3'd7;

    // item codes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // status of the remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_stat;

endpackage

@@ rtl/wps_rem.sv @@
// ---------------------------------------------------------------------------
// wps_rem: bit-serial truncating remainder
// restoring remainder of a signed dividend by an unsigned span, one bit a cycle
// ---------------------------------------------------------------------------
module wps_rem #(
    parameter int DIV_W = 19
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [DIV_W-1:0]          i_dividend,
    input  logic [wps_pkg::REM_W-1:0]        i_span,
    output wps_pkg::t_rem_stat               o_stat,
    output logic signed [wps_pkg::WRAP_W-1:0] o_rem
);
    import wps_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_mag;
    logic [REM_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic             r_busy;
    logic             r_done;

    logic [DIV_W-1:0] start_mag;
    logic [REM_W:0]   trial;
    logic [REM_W:0]   trial_sub;

    assign start_mag = i_dividend[DIV_W-1] ? DIV_W'(-i_dividend) : DIV_W'(i_dividend);

    // shift in the next dividend bit, subtract span when it fits
    assign trial     = {r_rem, r_mag[DIV_W-1]};
    assign trial_sub = trial - (REM_W + 1)'(i_span);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= start_mag;
            r_neg <= i_dividend[DIV_W-1];
            r_rem <= '0;
            r_cnt <= CNT_W'(DIV_W);
        end else if (r_busy) begin
            r_mag <= {r_mag[DIV_W-2:0], 1'b0};
            r_cnt <= r_cnt - CNT_W'(1);
            if (trial >= (REM_W + 1)'(i_span)) begin
                r_rem <= trial_sub[REM_W-1:0];
            end else begin
                r_rem <= trial[REM_W-1:0];
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    // remainder takes the sign of the dividend
    assign o_rem = r_neg ? -WRAP_W'(r_rem) : WRAP_W'(r_rem);

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("remainder started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy) else $error("done without a run");
    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0 && r_cnt <= CNT_W'(DIV_W)))
        else $error("bit count out of range");

endmodule

@@ rtl/wrapped_pid_step.sv @@
// ---------------------------------------------------------------------------
// wrapped_pid_step: integer pid step with wrapped error, integral band, clamps
// error and measurement change wrapped by a truncating remainder, shared
// remainder unit and one shared 16x17 multiplier under a small sequencer
// ---------------------------------------------------------------------------
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+--------------------------------
//  input     | i_in_valid / o_in_ready   | i_op, i_measure
//  result    | o_out_valid / i_out_ready | o_drive, o_error_wrapped
//  config    | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
//  an update beat runs the bit-serial remainder twice, on the error and then on
//  the measurement change (dividend width DIV_W = max(DATA_WIDTH,17)+2), then
//  the integral, p and d steps on the multiplier and the done state; a clear
//  beat goes straight to the done state; a new beat is taken only in idle
//  reset is synchronous, active low; wrap_half resets to 16383, other config,
//  state, integral, last sample and output valid to 0; a finished result waits
//  in the output register; the next input beat is taken meanwhile, and the
//  sequencer holds at its end until the slot is free
module wrapped_pid_step #(
    parameter int DATA_WIDTH = wps_pkg::DATA_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config port
    input  logic                               i_cfg_we,
    input  logic [wps_pkg::IDX_W-1:0]          i_cfg_idx,
    input  logic [wps_pkg::CFG_W-1:0]          i_cfg_data,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_op,
    input  logic signed [DATA_WIDTH-1:0]       i_measure,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [wps_pkg::DRIVE_W-1:0] o_drive,
    output logic signed [wps_pkg::ERR_W-1:0]   o_error_wrapped
);
    import wps_pkg::*;

    // difference width, then wrap-sum width fed to the remainder unit
    localparam int DIFF_W = ((DATA_WIDTH > GAIN_W) ? DATA_WIDTH : GAIN_W) + 1;
    localparam int DIV_W  = ((DIFF_W > 18) ? DIFF_W : 18) + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_REM_E = 3'd1;
    localparam logic [2:0] S_REM_C = 3'd2;
    localparam logic [2:0] S_MUL_I = 3'd3;
    localparam logic [2:0] S_INTEG = 3'd4;
    localparam logic [2:0] S_PTERM = 3'd5;
    localparam logic [2:0] S_DTERM = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // config registers
    logic signed [GAIN_W-1:0] r_gain_p;
    logic signed [GAIN_W-1:0] r_gain_i;
    logic signed [GAIN_W-1:0] r_gain_d;
    logic signed [GAIN_W-1:0] r_setpoint;
    logic [HALF_W-1:0]        r_wrap_half;
    logic [LIM_W-1:0]         r_integ_band;
    logic [LIM_W-1:0]         r_integ_limit;
    logic [LIM_W-1:0]         r_drive_limit;

    // sequencer and datapath
    logic [2:0]                  r_state;
    logic signed [DATA_WIDTH-1:0] r_meas;
    logic signed [DATA_WIDTH-1:0] r_prev;
    logic signed [DRIVE_W-1:0]   r_integ;
    logic signed [WRAP_W-1:0]    r_err;
    logic signed [WRAP_W-1:0]    r_chg;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]     r_acc;

    // output slot
    logic                        r_out_valid;
    logic signed [DRIVE_W-1:0]   r_drive;
    logic signed [ERR_W-1:0]     r_err_out;

    logic                        in_beat;
    logic                        rem_start;
    logic signed [DIV_W-1:0]     rem_div;
    logic signed [DIV_W-1:0]     div_err;
    logic signed [DIV_W-1:0]     div_chg;
    logic [16:0]                 half_x5;
    logic [REM_W-1:0]            span;
    t_rem_stat                   rem_stat;
    logic signed [WRAP_W-1:0]    rem_val;
    logic signed [WRAP_W-1:0]    wrap_val;
    logic signed [GAIN_W-1:0]    mul_a;
    logic signed [WRAP_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]    mul_p;
    logic [WRAP_W-1:0]           err_abs;
    logic                        out_band;
    logic signed [INTEG_W-1:0]   integ_raw;
    logic signed [INTEG_W-1:0]   integ_lim;
    logic signed [DRIVE_W-1:0]   integ_next;
    logic signed [ACC_W-1:0]     drive_lim;
    logic signed [DRIVE_W-1:0]   drive_next;
    logic                        slot_free;

    // config writes, masked to each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p      <= '0;
            r_gain_i      <= '0;
            r_gain_d      <= '0;
            r_setpoint    <= '0;
            r_wrap_half   <= HALF_RST;
            r_integ_band  <= '0;
            r_integ_limit <= '0;
            r_drive_limit <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GAIN_P:      r_gain_p      <= i_cfg_data;
                REG_GAIN_I:      r_gain_i      <= i_cfg_data;
                REG_GAIN_D:      r_gain_d      <= i_cfg_data;
                REG_SETPOINT:    r_setpoint    <= i_cfg_data;
                REG_WRAP_HALF:   r_wrap_half   <= i_cfg_data[HALF_W-1:0];
                REG_INTEG_BAND:  r_integ_band  <= i_cfg_data[LIM_W-1:0];
                REG_INTEG_LIMIT: r_integ_limit <= i_cfg_data[LIM_W-1:0];
                REG_DRIVE_LIMIT: r_drive_limit <= i_cfg_data[LIM_W-1:0];
                default:         r_gain_p      <= r_gain_p;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_beat    = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;

    // wrap sums: x + 5*half, error straight from the input beat
    assign half_x5 = {1'b0, r_wrap_half, 2'b00} + 17'(r_wrap_half);
    assign span    = {r_wrap_half, 1'b0};
    assign div_err = DIV_W'(i_measure) - DIV_W'(r_setpoint) + DIV_W'(half_x5);
    assign div_chg = DIV_W'(r_meas) - DIV_W'(r_prev) + DIV_W'(half_x5);

    assign rem_start = (in_beat && i_op == OP_UPDATE) ||
                       (r_state == S_REM_E && rem_stat.done);
    assign rem_div   = (r_state == S_IDLE) ? div_err : div_chg;

    wps_rem #(
        .DIV_W (DIV_W)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (rem_div),
        .i_span     (span),
        .o_stat     (rem_stat),
        .o_rem      (rem_val)
    );

    // zero half span means no wrap range at all
    assign wrap_val = (r_wrap_half == '0) ? '0 : rem_val - WRAP_W'(r_wrap_half);

    // shared multiplier, operands picked by the sequencer
    always_comb begin
        unique case (r_state)
            S_MUL_I: begin
                mul_a = r_gain_i;
                mul_b = r_err;
            end
            S_INTEG: begin
                mul_a = r_gain_p;
                mul_b = r_err;
            end
            default: begin
                mul_a = r_gain_d;
                mul_b = r_chg;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // integral: band reset, accumulate, clamp
    assign err_abs   = r_err[WRAP_W-1] ? WRAP_W'(-r_err) : WRAP_W'(r_err);
    assign out_band  = (r_integ_band != '0) && (err_abs > WRAP_W'(r_integ_band));
    assign integ_raw = out_band ? '0 : INTEG_W'(r_integ) + INTEG_W'(r_prod);
    assign integ_lim = INTEG_W'(r_integ_limit);

    always_comb begin
        priority if (integ_raw > integ_lim) begin
            integ_next = DRIVE_W'(integ_lim);
        end else if (integ_raw < -integ_lim) begin
            integ_next = DRIVE_W'(-integ_lim);
        end else begin
            integ_next = integ_raw[DRIVE_W-1:0];
        end
    end

    // drive clamp
    assign drive_lim = ACC_W'(r_drive_limit);

    always_comb begin
        priority if (r_acc > drive_lim) begin
            drive_next = DRIVE_W'(drive_lim);
        end else if (r_acc < -drive_lim) begin
            drive_next = DRIVE_W'(-drive_lim);
        end else begin
            drive_next = r_acc[DRIVE_W-1:0];
        end
    end

    // sequencer and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prev  <= '0;
            r_integ <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        if (i_op == OP_CLEAR) begin
                            r_prev  <= '0;
                            r_integ <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_REM_E;
                        end
                    end
                end
                S_REM_E: begin
                    if (rem_stat.done) begin
                        r_state <= S_REM_C;
                    end
                end
                S_REM_C: begin
                    if (rem_stat.done) begin
                        r_prev  <= r_meas;
                        r_state <= S_MUL_I;
                    end
                end
                S_MUL_I: r_state <= S_INTEG;
                S_INTEG: begin
                    r_integ <= integ_next;
                    r_state <= S_PTERM;
                end
                S_PTERM: r_state <= S_DTERM;
                S_DTERM: r_state <= S_DONE;
                S_DONE: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (in_beat) begin
            r_meas <= i_measure;
            if (i_op == OP_CLEAR) begin
                r_err <= '0;
                r_acc <= '0;
            end
        end
        if (r_state == S_REM_E && rem_stat.done) begin
            r_err <= wrap_val;
        end
        if (r_state == S_REM_C && rem_stat.done) begin
            r_chg <= wrap_val;
        end
        if (r_state == S_PTERM) begin
            r_acc <= ACC_W'(r_integ) + ACC_W'(r_prod);
        end
        if (r_state == S_DTERM) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && slot_free) begin
            r_drive   <= drive_next;
            r_err_out <= r_err[ERR_W-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_drive         = r_drive;
    assign o_error_wrapped = r_err_out;

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !o_in_ready) else $error("ready stayed high after a beat");
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && i_op == OP_CLEAR) |=> (r_acc == '0 && r_err == '0 &&
        r_integ == '0 && r_prev == '0)) else $error("clear left state");
    a_rem_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_stat.done |-> (r_state == S_REM_E || r_state == S_REM_C))
        else $error("remainder result outside a wrap step");
    a_integ_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PTERM |-> (INTEG_W'(r_integ) <= integ_lim &&
        INTEG_W'(r_integ) >= -integ_lim)) else $error("integral beyond limit");

endmodule

@@ test/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the wrapped pid step block
// drives update and clear beats in random bursts, predicts drive and wrapped
// error for every accepted beat and compares them with the result channel
// under random back-pressure, over several register settings
// ---------------------------------------------------------------------------
module testbench;
    import wps_pkg::*;

    localparam int DW             = DATA_WIDTH_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int PRINT_LIMIT    = 50;

    // receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_ALTERNATE
    } t_rx_mode;

    // one result beat: drive and wrapped error
    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic signed [ERR_W-1:0]   err;
    } t_pid_out;

    // clock and reset
    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    // dut stimulus, all known from time zero
    logic                 cfg_we   = 1'b0;
    logic [IDX_W-1:0]     cfg_idx  = REG_GAIN_P;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 op       = OP_UPDATE;
    logic signed [DW-1:0] measure  = '0;
    logic                 out_ready = 1'b0;

    // dut outputs
    logic                      in_ready;
    logic                      out_valid;
    logic signed [DRIVE_W-1:0] drive;
    logic signed [ERR_W-1:0]   error_wrapped;

    // register shadow, masked like the block's registers
    logic signed [GAIN_W-1:0] kp = '0;
    logic signed [GAIN_W-1:0] ki = '0;
    logic signed [GAIN_W-1:0] kd = '0;
    logic signed [GAIN_W-1:0] target = '0;
    logic [HALF_W-1:0]        half_span = HALF_RST;
    logic [LIM_W-1:0]         band_width = '0;
    logic [LIM_W-1:0]         integ_clamp = '0;
    logic [LIM_W-1:0]         drive_clamp = '0;

    // controller state mirror
    longint last_meas = 0;
    longint integ_acc = 0;

    // results predicted but not yet seen, oldest first
    t_pid_out step_results_due[$];

    int mismatch_count = 0;
    int stalled_cycles = 0;
    int hold_request   = 0;
    int hold_seq       = 0;

    // 10 time unit clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    wrapped_pid_step u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_op            (op),
        .i_measure       (measure),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_drive         (drive),
        .o_error_wrapped (error_wrapped)
    );

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // wrap into [-half, half) with a remainder that truncates toward zero;
    // a negative sum keeps its negative remainder, so values can go below
    // -half when half is small
    function automatic longint wrap_span(longint x);
        longint h;
        h = longint'(half_span);
        if (h == 0) begin
            return 0;
        end
        return (x + 5 * h) % (2 * h) - h;
    endfunction

    function automatic longint clamp_sym(longint v, longint lim);
        longint mag;
        mag = (v < 0) ? -v : v;
        if (mag > lim) begin
            return (v > 0) ? lim : -lim;
        end
        return v;
    endfunction

    // one controller step: updates the state mirror, returns the result beat
    function automatic t_pid_out compute_pid_step(logic item_op, logic signed [DW-1:0] sample);
        t_pid_out r;
        longint   e;
        longint   chg;
        longint   mag;
        longint   sum;
        r = '0;
        if (item_op == OP_CLEAR) begin
            last_meas = 0;
            integ_acc = 0;
            return r;
        end
        e   = wrap_span(longint'(sample) - longint'(target));
        chg = wrap_span(longint'(sample) - last_meas);
        last_meas = longint'(sample);
        mag = (e < 0) ? -e : e;
        // integral is dropped when the error leaves a nonzero band
        if (band_width != 0 && mag > longint'(band_width)) begin
            integ_acc = 0;
        end else begin
            integ_acc = integ_acc + longint'(ki) * e;
        end
        integ_acc = clamp_sym(integ_acc, longint'(integ_clamp));
        // derivative acts on the measurement change, not on the error
        sum = longint'(kp) * e + integ_acc + longint'(kd) * chg;
        sum = clamp_sym(sum, longint'(drive_clamp));
        r.drive = sum[DRIVE_W-1:0];
        r.err   = e[ERR_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // compare every accepted result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_pid_out want;
        if (rst_n && out_valid && out_ready) begin
            if (step_results_due.size() == 0) begin
                report_mismatch("result beat with nothing pending", drive, 0);
            end else begin
                want = step_results_due.pop_front();
                if (drive !== want.drive) begin
                    report_mismatch("drive", drive, want.drive);
                end
                if (error_wrapped !== want.err) begin
                    report_mismatch("error_wrapped", error_wrapped, want.err);
                end
            end
        end
    end

    // cycles without any beat on either channel
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial begin
        while (stalled_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: own stall pattern, plus long hold-offs on request
    // ------------------------------------------------------------------
    t_rx_mode rx_mode   = RX_OPEN;
    int       mode_left = 0;
    int       hold_left = 0;
    int       hold_seen = 0;

    always @(negedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_left = hold_request;
            hold_seen = hold_seq;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready = 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:  out_ready = 1'b1;
                RX_LIGHT: out_ready = ($urandom_range(0, 3) != 0);
                RX_HEAVY: out_ready = ($urandom_range(0, 3) == 0);
                default:  out_ready = ~out_ready;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sender and register access
    // ------------------------------------------------------------------

    // offer one beat and hold it until accepted; valid stays high after
    task automatic send_item(logic item_op, logic signed [DW-1:0] sample);
        @(negedge i_clk);
        in_valid = 1'b1;
        op       = item_op;
        measure  = sample;
        @(posedge i_clk);
        while (!in_ready) begin
            @(posedge i_clk);
        end
        step_results_due.push_back(compute_pid_step(item_op, sample));
    endtask

    task automatic idle_input(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            in_valid = 1'b0;
        end
    endtask

    // sender pauses until every predicted result has come back
    task automatic wait_drained();
        idle_input(1);
        while (step_results_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        case (idx)
            REG_GAIN_P:      kp          = data;
            REG_GAIN_I:      ki          = data;
            REG_GAIN_D:      kd          = data;
            REG_SETPOINT:    target      = data;
            REG_WRAP_HALF:   half_span   = data[HALF_W-1:0];
            REG_INTEG_BAND:  band_width  = data[LIM_W-1:0];
            REG_INTEG_LIMIT: integ_clamp = data[LIM_W-1:0];
            REG_DRIVE_LIMIT: drive_clamp = data[LIM_W-1:0];
            default: ;
        endcase
    endtask

    // only called with nothing in flight
    task automatic set_registers(logic [CFG_W-1:0] p, logic [CFG_W-1:0] i,
                                 logic [CFG_W-1:0] d, logic [CFG_W-1:0] sp,
                                 logic [CFG_W-1:0] half, logic [CFG_W-1:0] band,
                                 logic [CFG_W-1:0] ilim, logic [CFG_W-1:0] dlim);
        write_reg(REG_GAIN_P, p);
        write_reg(REG_GAIN_I, i);
        write_reg(REG_GAIN_D, d);
        write_reg(REG_SETPOINT, sp);
        write_reg(REG_WRAP_HALF, half);
        write_reg(REG_INTEG_BAND, band);
        write_reg(REG_INTEG_LIMIT, ilim);
        write_reg(REG_DRIVE_LIMIT, dlim);
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // random content
    // ------------------------------------------------------------------

    function automatic logic [CFG_W-1:0] random_gain();
        case ($urandom_range(0, 3))
            0:       return CFG_W'($urandom);
            1:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return CFG_W'($urandom_range(0, 512) - 256);
        endcase
    endfunction

    // upper data bits beyond the register width are random to check masking
    function automatic logic [CFG_W-1:0] random_half();
        case ($urandom_range(0, 3))
            0:       return CFG_W'($urandom);
            1:       return CFG_W'($urandom_range(1, 16));
            2:       return CFG_W'($urandom_range(1, 16383));
            default: return {2'($urandom), 14'h3fff};
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_band();
        case ($urandom_range(0, 3))
            0, 1:    return {1'($urandom), 15'h0000};
            2:       return CFG_W'($urandom_range(1, 500));
            default: return CFG_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_limit();
        case ($urandom_range(0, 3))
            0:       return CFG_W'($urandom);
            1:       return {1'($urandom), 15'h7fff};
            2:       return CFG_W'($urandom_range(0, 2000));
            default: return CFG_W'($urandom_range(2000, 32767));
        endcase
    endfunction

    // mostly samples that settle around the target so the integral builds
    // up, with drift, noise and the extremes mixed in
    function automatic logic signed [DW-1:0] next_measure(logic signed [DW-1:0] prev);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
            return DW'(int'(target) + int'($urandom_range(0, 400)) - 200);
        end else if (pick < 14) begin
            return DW'(int'(prev) + int'($urandom_range(0, 64)) - 32);
        end else if (pick < 19) begin
            return DW'($urandom);
        end
        return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endfunction

    // bursts of random length with random gaps, or back to back
    task automatic send_random_items(int count, bit gappy);
        int                   burst_left;
        logic signed [DW-1:0] sample;
        logic                 item_op;
        burst_left = 0;
        sample     = target;
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if (gappy && $urandom_range(0, 3) != 0) begin
                    idle_input($urandom_range(1, 12));
                end
            end
            burst_left--;
            item_op = ($urandom_range(0, 24) == 0) ? OP_CLEAR : OP_UPDATE;
            sample  = next_measure(sample);
            send_item(item_op, sample);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset register values: zero gains and clamps, full wrap span
    task automatic test_reset_values();
        send_item(OP_UPDATE, 16'sh7fff);
        send_item(OP_UPDATE, 16'sh8000);
        send_item(OP_UPDATE, 16'sh0000);
        wait_drained();
    endtask

    task automatic test_directed_cases();
        // full-scale gains and clamps: saturation both ways, clear in between
        set_registers(16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                      16'h3fff, 16'h0000, 16'h7fff, 16'h7fff);
        send_item(OP_UPDATE, 16'sh7fff);
        send_item(OP_UPDATE, 16'sh8000);
        send_item(OP_UPDATE, 16'sh0000);
        send_item(OP_CLEAR, 16'sh7fff);
        send_item(OP_UPDATE, 16'sh0001);
        wait_drained();

        // zero wrap span through masked upper data bits: both wrapped values 0
        set_registers(16'h0001, 16'h0001, 16'h0001, 16'h0000,
                      16'hc000, 16'h0000, 16'h7fff, 16'h7fff);
        send_item(OP_UPDATE, 16'sd100);
        send_item(OP_UPDATE, -16'sd100);
        wait_drained();

        // tiny span with a large negative difference: wrap sum below zero
        set_registers(16'h0001, 16'h0001, 16'hffff, 16'h7fff,
                      16'h0004, 16'h0000, 16'h7fff, 16'h7fff);
        send_item(OP_UPDATE, 16'sh8000);
        send_item(OP_UPDATE, 16'sh7fff);
        send_item(OP_UPDATE, -16'sd32000);
        wait_drained();

        // integral band: inside accumulates, exactly on the edge kept,
        // outside zeroes, clamp on the integral
        set_registers(16'h0000, 16'd100, 16'h0000, 16'h0000,
                      16'h3fff, 16'd100, 16'd1000, 16'h7fff);
        send_item(OP_UPDATE, 16'sd50);
        send_item(OP_UPDATE, 16'sd60);
        send_item(OP_UPDATE, 16'sd500);
        send_item(OP_UPDATE, 16'sd100);
        send_item(OP_UPDATE, -16'sd101);
        send_item(OP_CLEAR, 16'sd0);
        wait_drained();
    endtask

    // receiver holds off long while the sender keeps offering, so the
    // block fills and stalls its input; then the sender waits for all results
    task automatic test_output_backpressure();
        set_registers(16'd3, 16'd2, 16'hfffb, 16'd1000,
                      16'h3fff, 16'd0, 16'd20000, 16'd30000);
        @(posedge i_clk);
        hold_request = 400;
        hold_seq++;
        send_random_items(16, 1'b0);
        wait_drained();
    endtask

    // several register settings, extremes first, then random ones
    task automatic test_random_settings();
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: set_registers(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                 16'h3fff, 16'h7fff, 16'h7fff, 16'h7fff);
                1: set_registers(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                 16'h0001, 16'h0000, 16'h0000, 16'h0000);
                default: set_registers(random_gain(), random_gain(), random_gain(),
                                       CFG_W'($urandom), random_half(), random_band(),
                                       random_limit(), random_limit());
            endcase
            send_random_items((phase < 2) ? 60 : 200, (phase % 3) != 2);
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        rst_n = 1'b1;

        test_reset_values();
        test_directed_cases();
        test_output_backpressure();
        test_random_settings();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/wps_pkg.sv
rtl/wps_rem.sv
rtl/wrapped_pid_step.sv
test/testbench.sv
